@@ rtl/hvt_pkg.sv @@
package hvt_pkg;

    // Default fraction bits of the signed fixed-point format
    localparam int FRAC_BITS_DEF = 16;

    // Field and register widths
    localparam int COORD_W   = 32;
    localparam int PROD_W    = 2 * COORD_W;
    localparam int CFG_W     = 64;
    localparam int NUM_REGS  = 8;
    localparam int IDX_W     = 4;
    localparam int REG_SEL_W = $clog2(NUM_REGS);
    localparam int NUM_COLS  = 4;
    localparam int NUM_AXES  = 3;

    // Exact column sum: three 64-bit products plus the translation term
    localparam int SUM_W = PROD_W + 2;

    // Quotient bits produced by the divider before saturation
    localparam int Q_W = COORD_W;

    // Pipeline depths
    localparam int MAC_LAT = 3;
    localparam int DIV_LAT = Q_W + 3;
    localparam int LAT     = MAC_LAT + DIV_LAT;

    localparam logic [COORD_W-1:0] SAT_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic [COORD_W-1:0] SAT_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef struct packed {
        logic               w_was_zero;
        logic [COORD_W-1:0] out_z;
        logic [COORD_W-1:0] out_y;
        logic [COORD_W-1:0] out_x;
    } t_result;

endpackage

@@ rtl/hvt_mac_lane.sv @@
module hvt_mac_lane #(
    parameter int FRAC_BITS = hvt_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [hvt_pkg::COORD_W-1:0]  i_x,
    input  logic signed [hvt_pkg::COORD_W-1:0]  i_y,
    input  logic signed [hvt_pkg::COORD_W-1:0]  i_z,
    input  logic signed [hvt_pkg::COORD_W-1:0]  i_m0,
    input  logic signed [hvt_pkg::COORD_W-1:0]  i_m1,
    input  logic signed [hvt_pkg::COORD_W-1:0]  i_m2,
    input  logic signed [hvt_pkg::COORD_W-1:0]  i_m3,
    output logic signed [hvt_pkg::SUM_W-1:0]    o_sum
);
    import hvt_pkg::*;

    localparam int EXT_W = SUM_W - PROD_W;
    localparam int TR_W  = SUM_W - COORD_W - FRAC_BITS;

    logic signed [PROD_W-1:0] r_p0, r_p1, r_p2;
    logic        [SUM_W-1:0]  r_t;
    logic        [SUM_W-1:0]  r_a, r_b;
    logic        [SUM_W-1:0]  r_sum;

    // Multiply stage: one product per matrix row, translation aligned to the product scale
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p0 <= i_x * i_m0;
            r_p1 <= i_y * i_m1;
            r_p2 <= i_z * i_m2;
            r_t  <= {{TR_W{i_m3[COORD_W-1]}}, i_m3, {FRAC_BITS{1'b0}}};
        end
    end

    // Two add stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a   <= {{EXT_W{r_p0[PROD_W-1]}}, r_p0} + {{EXT_W{r_p1[PROD_W-1]}}, r_p1};
            r_b   <= {{EXT_W{r_p2[PROD_W-1]}}, r_p2} + r_t;
            r_sum <= r_a + r_b;
        end
    end

    assign o_sum = $signed(r_sum);

endmodule

@@ rtl/hvt_div_lane.sv @@
module hvt_div_lane #(
    parameter int FRAC_BITS = hvt_pkg::FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_en,
    input  logic signed [hvt_pkg::SUM_W-1:0]    i_sum,
    input  logic signed [hvt_pkg::SUM_W-1:0]    i_w,
    output logic        [hvt_pkg::COORD_W-1:0]  o_res,
    output logic                                o_wzero
);
    import hvt_pkg::*;

    localparam int MAG_W = SUM_W;
    localparam int NUM_W = MAG_W + FRAC_BITS;
    localparam int CMP_W = MAG_W + Q_W;

    // Prepare stage
    logic signed [SUM_W-1:0] w_shr;
    logic                    w_in_range;
    logic                    w_xneg, w_wneg;

    logic [MAG_W-1:0]   r_xmag, r_wmag;
    logic               r_qneg, r_wz;
    logic [COORD_W-1:0] r_zres;

    assign w_shr      = i_sum >>> FRAC_BITS;
    assign w_in_range = (&w_shr[SUM_W-1:COORD_W-1]) || !(|w_shr[SUM_W-1:COORD_W-1]);
    assign w_xneg     = i_sum[SUM_W-1];
    assign w_wneg     = i_w[SUM_W-1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xmag <= w_xneg ? (~i_sum + 1'b1) : i_sum;
            r_wmag <= w_wneg ? (~i_w + 1'b1) : i_w;
            r_qneg <= w_xneg ^ w_wneg;
            r_wz   <= (i_w == '0);
            if (w_in_range) begin
                r_zres <= w_shr[COORD_W-1:0];
            end else begin
                r_zres <= w_shr[SUM_W-1] ? SAT_MIN : SAT_MAX;
            end
        end
    end

    // Overflow test and initial remainder: quotient fits in Q_W bits iff num < den * 2^Q_W
    logic [NUM_W-1:0] w_num;
    logic             w_ovf;

    assign w_num = {r_xmag, {FRAC_BITS{1'b0}}};
    assign w_ovf = {{(CMP_W-NUM_W){1'b0}}, w_num} >= {r_wmag, {Q_W{1'b0}}};

    logic [MAG_W-1:0]   r_rem  [0:Q_W];
    logic [Q_W-1:0]     r_low  [0:Q_W];
    logic [Q_W-1:0]     r_q    [0:Q_W];
    logic [MAG_W-1:0]   r_den  [0:Q_W];
    logic               r_ovf  [0:Q_W];
    logic               r_sgn  [0:Q_W];
    logic               r_wzs  [0:Q_W];
    logic [COORD_W-1:0] r_zr   [0:Q_W];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= MAG_W'(w_num[NUM_W-1:Q_W]);
            r_low[0] <= w_num[Q_W-1:0];
            r_q[0]   <= '0;
            r_den[0] <= r_wmag;
            r_ovf[0] <= w_ovf;
            r_sgn[0] <= r_qneg;
            r_wzs[0] <= r_wz;
            r_zr[0]  <= r_zres;
        end
    end

    // One restoring step per stage, one quotient bit each
    for (genvar k = 0; k < Q_W; k++) begin : g_step
        logic [MAG_W:0] w_trial;
        logic           w_ge;

        assign w_trial = {r_rem[k], r_low[k][Q_W-1]};
        assign w_ge    = w_trial >= {1'b0, r_den[k]};

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1] <= w_ge ? MAG_W'(w_trial - {1'b0, r_den[k]})
                                   : w_trial[MAG_W-1:0];
                r_low[k+1] <= {r_low[k][Q_W-2:0], 1'b0};
                r_q[k+1]   <= {r_q[k][Q_W-2:0], w_ge};
                r_den[k+1] <= r_den[k];
                r_ovf[k+1] <= r_ovf[k];
                r_sgn[k+1] <= r_sgn[k];
                r_wzs[k+1] <= r_wzs[k];
                r_zr[k+1]  <= r_zr[k];
            end
        end
    end

    // Sign and saturate
    logic [Q_W-1:0]     w_q;
    logic [COORD_W-1:0] r_res;
    logic               r_wz_out;

    assign w_q = r_q[Q_W];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_wz_out <= r_wzs[Q_W];
            if (r_wzs[Q_W]) begin
                r_res <= r_zr[Q_W];
            end else if (r_ovf[Q_W]) begin
                r_res <= r_sgn[Q_W] ? SAT_MIN : SAT_MAX;
            end else if (r_sgn[Q_W]) begin
                r_res <= (w_q[Q_W-1] && (|w_q[Q_W-2:0])) ? SAT_MIN : (~w_q + 1'b1);
            end else begin
                r_res <= w_q[Q_W-1] ? SAT_MAX : w_q;
            end
        end
    end

    assign o_res   = r_res;
    assign o_wzero = r_wz_out;

endmodule

@@ rtl/hvt_merge.sv @@
module hvt_merge (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  logic [hvt_pkg::COORD_W-1:0]         i_lane_res [hvt_pkg::NUM_AXES],
    input  logic [hvt_pkg::NUM_AXES-1:0]        i_wzero,
    output logic                                o_ready,
    output logic                                o_valid,
    input  logic                                i_ready,
    output hvt_pkg::t_result                    o_res
);
    import hvt_pkg::*;

    t_result w_res;
    t_result r_out, r_skid;
    logic    r_out_vld, r_skid_full;
    logic    n_out_vld, n_skid_full;
    logic    w_load_out, w_load_skid, w_unskid;

    // Lanes agree on the zero flag; combine the three axis results into one request
    assign w_res.w_was_zero = |i_wzero;
    assign w_res.out_x      = i_lane_res[0];
    assign w_res.out_y      = i_lane_res[1];
    assign w_res.out_z      = i_lane_res[2];

    always_comb begin
        n_out_vld   = r_out_vld;
        n_skid_full = r_skid_full;
        w_load_out  = 1'b0;
        w_load_skid = 1'b0;
        w_unskid    = 1'b0;
        if (r_skid_full) begin
            if (i_ready) begin
                w_unskid    = 1'b1;
                n_skid_full = 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_vld || i_ready) begin
                w_load_out = 1'b1;
                n_out_vld  = 1'b1;
            end else begin
                w_load_skid = 1'b1;
                n_skid_full = 1'b1;
            end
        end else if (i_ready) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld   <= 1'b0;
            r_skid_full <= 1'b0;
        end else begin
            r_out_vld   <= n_out_vld;
            r_skid_full <= n_skid_full;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out <= w_res;
        end else if (w_unskid) begin
            r_out <= r_skid;
        end
        if (w_load_skid) begin
            r_skid <= w_res;
        end
    end

    assign o_ready = !r_skid_full;
    assign o_valid = r_out_vld;
    assign o_res   = r_out;

endmodule

@@ rtl/homogeneous_vertex_transform_unit.sv @@
// Homogeneous 4x4 vertex transform with perspective divide. Each request on the
// slave stream is one point (x, y, z) in signed fixed point with FRAC_BITS fraction
// bits; it is taken as the row vector (x, y, z, 1) and multiplied by the matrix held
// in eight 64-bit registers (entry r,c in register 2r + c/2, even column in the low
// half). The four column sums are exact; x', y', z' are then divided by w and
// saturated to 32 bits. When w is exactly zero the sums pass through shifted down by
// FRAC_BITS and saturated, and tuser is raised. Throughput is one point per clock
// while the output buffer has room. Registers in order: multiply-add lanes, operand
// preparation, divider initial remainder, quotient stages (one quotient bit per
// stage, each a 67-bit compare and subtract), final saturation, output register. A
// two-entry output buffer decouples the two streams, so s_axis_tready is a register
// and does not follow m_axis_tready in the same cycle. Matrix registers reset to
// zero; indexes past seven are ignored. The user must write them through the plain
// write port only while no point is in flight; the block does not enforce this.
module homogeneous_vertex_transform_unit #(
    parameter int FRAC_BITS = hvt_pkg::FRAC_BITS_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // Slave stream, tdata: in_x [31:0], in_y [63:32], in_z [95:64]
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  logic [3*hvt_pkg::COORD_W-1:0]           s_axis_tdata,
    // Master stream, tdata: out_x [31:0], out_y [63:32], out_z [95:64]
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    output logic [3*hvt_pkg::COORD_W-1:0]           m_axis_tdata,
    // tuser: w_was_zero [0]
    output logic [0:0]                              m_axis_tuser,
    // Configuration write port
    input  logic                                    i_cfg_we,
    input  logic [hvt_pkg::IDX_W-1:0]               i_cfg_index,
    input  logic [hvt_pkg::CFG_W-1:0]               i_cfg_data
);
    import hvt_pkg::*;

    // Matrix registers
    logic [CFG_W-1:0] r_mat [NUM_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                r_mat[i] <= '0;
            end
        end else if (i_cfg_we && (i_cfg_index < IDX_W'(NUM_REGS))) begin
            r_mat[i_cfg_index[REG_SEL_W-1:0]] <= i_cfg_data;
        end
    end

    // Unpack entry (r, c): register 2r + c/2, high half for odd columns
    logic signed [COORD_W-1:0] w_m [NUM_COLS][NUM_COLS];

    for (genvar r = 0; r < NUM_COLS; r++) begin : g_row
        for (genvar c = 0; c < NUM_COLS; c++) begin : g_col
            if (c % 2 == 1) begin : g_hi
                assign w_m[r][c] = $signed(r_mat[2*r + c/2][CFG_W-1:COORD_W]);
            end else begin : g_lo
                assign w_m[r][c] = $signed(r_mat[2*r + c/2][COORD_W-1:0]);
            end
        end
    end

    // Input point
    logic signed [COORD_W-1:0] w_x, w_y, w_z;

    assign w_x = $signed(s_axis_tdata[COORD_W-1:0]);
    assign w_y = $signed(s_axis_tdata[2*COORD_W-1:COORD_W]);
    assign w_z = $signed(s_axis_tdata[3*COORD_W-1:2*COORD_W]);

    // Advance the whole pipeline whenever the output buffer has room
    logic w_en;

    assign s_axis_tready = w_en;

    // Valid marks travel alongside the data through all stages
    logic r_vld [LAT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LAT; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= s_axis_tvalid;
            for (int k = 1; k < LAT; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // One multiply-add lane per matrix column: x', y', z', w
    logic signed [SUM_W-1:0] w_sum [NUM_COLS];

    for (genvar c = 0; c < NUM_COLS; c++) begin : g_mac
        hvt_mac_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_mac (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_x   (w_x),
            .i_y   (w_y),
            .i_z   (w_z),
            .i_m0  (w_m[0][c]),
            .i_m1  (w_m[1][c]),
            .i_m2  (w_m[2][c]),
            .i_m3  (w_m[3][c]),
            .o_sum (w_sum[c])
        );
    end

    // One divider lane per axis, all sharing w
    logic [COORD_W-1:0]  w_res [NUM_AXES];
    logic [NUM_AXES-1:0] w_wz;

    for (genvar k = 0; k < NUM_AXES; k++) begin : g_div
        hvt_div_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .i_clk   (i_clk),
            .i_en    (w_en),
            .i_sum   (w_sum[k]),
            .i_w     (w_sum[NUM_COLS-1]),
            .o_res   (w_res[k]),
            .o_wzero (w_wz[k])
        );
    end

    // Merge the lanes into one request and hold it for the master stream
    t_result w_out;

    hvt_merge u_merge (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (r_vld[LAT-1]),
        .i_lane_res (w_res),
        .i_wzero    (w_wz),
        .o_ready    (w_en),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_res      (w_out)
    );

    assign m_axis_tdata = {w_out.out_z, w_out.out_y, w_out.out_x};
    assign m_axis_tuser = w_out.w_was_zero;

endmodule

@@ rtl/hvt_checker.sv @@
module hvt_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [3*hvt_pkg::COORD_W-1:0] m_axis_tdata,
    input logic [0:0]                    m_axis_tuser
);

    // Reset empties the output buffer
    a_reset_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // Stalled request holds
    a_out_hold : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled output request changed");

    // Input stalls only while a result is waiting
    a_ready_when_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // A drained spare entry frees the input on the next cycle
    a_ready_after_drain : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready && m_axis_tready |=> s_axis_tready)
        else $error("input still stalled after output drained");

endmodule

bind homogeneous_vertex_transform_unit hvt_checker u_hvt_checker (.*);

@@ sim/tb_homogeneous_vertex_transform_unit.sv @@
`timescale 1ns / 1ps

module tb_homogeneous_vertex_transform_unit;

    import hvt_pkg::*;

    localparam int FRAC         = FRAC_BITS_DEF;
    localparam int POINT_TARGET = 1750;
    localparam logic [31:0] Q_ONE = 32'h0001_0000;

    localparam logic signed [127:0] POS_LIM = 128'sd2147483647;
    localparam logic signed [127:0] NEG_LIM = -128'sd2147483648;

    // Matrix presets of the directed part; MAT_RESET means "leave the reset state"
    typedef enum logic [2:0] {
        MAT_RESET,
        MAT_IDENTITY,
        MAT_FLAT,
        MAT_PERSP,
        MAT_POS_MAX,
        MAT_NEG_MAX
    } t_mat_preset;

    // Matrix shapes of the random part
    typedef enum logic [1:0] {
        RND_BITS,
        RND_AFFINE,
        RND_PROJ,
        RND_FLAT
    } t_rand_kind;

    typedef struct packed {
        t_mat_preset preset;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        has_golden;
        t_result     golden;
    } t_vertex_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [3*COORD_W-1:0] s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [3*COORD_W-1:0] m_axis_tdata;
    logic [0:0]           m_axis_tuser;
    logic                 i_cfg_we = 1'b0;
    logic [IDX_W-1:0]     i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    // Shadow of the matrix registers, as the block should hold them
    logic [CFG_W-1:0] matrix_q [NUM_REGS];

    // Results still owed by the block, oldest first
    t_result     projected_vertex_q [$];
    t_vertex_row directed_rows [$];

    int mismatch_count  = 0;
    int points_sent     = 0;
    int flat_count      = 0;
    int matrix_settings = 0;
    int stall_left      = 0;
    bit steady          = 1'b0;

    homogeneous_vertex_transform_unit #(
        .FRAC_BITS(FRAC)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop far beyond the slowest legal run
    initial begin
        #8_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Sign-extended matrix entry (r, c): register 2r + c/2, odd column in the high half
    function automatic logic signed [127:0] matrix_entry(input int r, input int c);
        logic [CFG_W-1:0]   regv;
        logic signed [31:0] e;
        regv = matrix_q[2*r + c/2];
        e = (c % 2 != 0) ? regv[63:32] : regv[31:0];
        return e;
    endfunction

    function automatic logic [31:0] clamp_q(input logic signed [127:0] v);
        if (v > POS_LIM)
            return SAT_MAX;
        else if (v < NEG_LIM)
            return SAT_MIN;
        return v[31:0];
    endfunction

    // Row vector (x, y, z, 1) times the matrix, then perspective divide by w
    function automatic t_result project_vertex(input logic [31:0] x, y, z);
        logic signed [127:0] px, py, pz;
        logic signed [127:0] col [4];
        logic signed [127:0] v;
        logic [127:0]        wmag, mag, quo;
        logic [2:0][31:0]    lanes;
        logic                wneg, wzero;
        t_result             r;
        px = $signed(x);
        py = $signed(y);
        pz = $signed(z);
        for (int c = 0; c < NUM_COLS; c++) begin
            // Translation row carries twice the fraction bits after alignment
            col[c] = matrix_entry(3, c) <<< FRAC;
            col[c] = col[c] + px * matrix_entry(0, c) + py * matrix_entry(1, c)
                     + pz * matrix_entry(2, c);
        end
        wzero = (col[3] == 0);
        wneg  = col[3][127];
        wmag  = wneg ? -col[3] : col[3];
        for (int k = 0; k < NUM_AXES; k++) begin
            if (wzero) begin
                // No divide: drop back to single fraction, rounding toward minus infinity
                v = col[k] >>> FRAC;
            end else begin
                mag = col[k][127] ? -col[k] : col[k];
                quo = (mag << FRAC) / wmag;
                v = (col[k][127] != wneg) ? -$signed(quo) : $signed(quo);
            end
            lanes[k] = clamp_q(v);
        end
        r.out_x      = lanes[0];
        r.out_y      = lanes[1];
        r.out_z      = lanes[2];
        r.w_was_zero = wzero;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    function automatic void add_row(input t_mat_preset p, input logic [31:0] x, y, z);
        t_vertex_row row;
        row = '0;
        row.preset = p;
        row.x = x;
        row.y = y;
        row.z = z;
        directed_rows.push_back(row);
    endfunction

    // Row whose result is obvious from the matrix, typed in by hand
    function automatic void add_known(input t_mat_preset p, input logic [31:0] x, y, z,
                                      input logic [31:0] gx, gy, gz, input logic gw);
        t_vertex_row row;
        row.preset            = p;
        row.x                 = x;
        row.y                 = y;
        row.z                 = z;
        row.has_golden        = 1'b1;
        row.golden.out_x      = gx;
        row.golden.out_y      = gy;
        row.golden.out_z      = gz;
        row.golden.w_was_zero = gw;
        directed_rows.push_back(row);
    endfunction

    // Mostly back-to-back, some short gaps, a rare long one
    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Entries packed as index r*4 + c
    function automatic logic [15:0][31:0] build_preset(input t_mat_preset p);
        logic [15:0][31:0] e;
        e = '0;
        case (p)
            MAT_IDENTITY: begin
                e[0] = Q_ONE; e[5] = Q_ONE; e[10] = Q_ONE; e[15] = Q_ONE;
            end
            MAT_FLAT: begin
                // w column all zero; translation with a tiny negative and a huge term
                e[0]  = 32'h0002_0000;
                e[5]  = 32'hFFFF_0000;
                e[10] = 32'h0000_8000;
                e[12] = 32'h0001_8000;
                e[13] = 32'hFFFF_FFFF;
                e[14] = 32'h7FFF_FFFF;
            end
            MAT_PERSP: begin
                // w = z: classic projection, z of zero gives w of zero
                e[0] = Q_ONE; e[5] = Q_ONE; e[10] = Q_ONE; e[11] = Q_ONE;
            end
            MAT_POS_MAX: e = {16{32'h7FFF_FFFF}};
            MAT_NEG_MAX: e = {16{32'h8000_0000}};
            default: e = '0;
        endcase
        return e;
    endfunction

    // Random entry within +/-8.0, zero a quarter of the time
    function automatic logic [31:0] rand_entry();
        if ($urandom_range(0, 3) == 0)
            return '0;
        return 32'($urandom_range(0, 32'h0010_0000)) - 32'h0008_0000;
    endfunction

    function automatic logic [15:0][31:0] rand_matrix(input t_rand_kind kind);
        logic [15:0][31:0] e;
        for (int i = 0; i < 16; i++)
            e[i] = (kind == RND_BITS) ? 32'($urandom) : rand_entry();
        case (kind)
            RND_AFFINE: begin
                e[3] = '0; e[7] = '0; e[11] = '0;
                e[15] = ($urandom_range(0, 3) == 0) ? rand_entry() : Q_ONE;
            end
            RND_PROJ: begin
                e[3] = '0; e[7] = '0; e[15] = '0;
                if (e[11] == '0)
                    e[11] = Q_ONE;
            end
            RND_FLAT: begin
                e[3] = '0; e[7] = '0; e[11] = '0; e[15] = '0;
            end
            default: ;
        endcase
        return e;
    endfunction

    function automatic logic [31:0] rand_coord();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 32'($urandom_range(0, 32'h0800_0000)) - 32'h0400_0000;
        if (r < 80)
            return 32'($urandom);
        if (r < 90) begin
            case ($urandom_range(0, 5))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 32'h0000_0000;
                3: return 32'h0000_0001;
                4: return 32'hFFFF_FFFF;
                default: return Q_ONE;
            endcase
        end
        return 32'($urandom_range(0, 510)) - 32'd255;
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    task automatic write_cfg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        // Indexes past seven must be dropped by the block
        if (idx < NUM_REGS)
            matrix_q[idx[REG_SEL_W-1:0]] = val;
    endtask

    // Drain the pipe, then load the registers picked by mask plus one stray write
    task automatic program_matrix(input logic [15:0][31:0] ent, input logic [7:0] mask);
        int base;
        s_axis_tvalid <= 1'b0;
        while (projected_vertex_q.size() != 0)
            @(posedge i_clk);
        for (int i = 0; i < NUM_REGS; i++) begin
            if (mask[i]) begin
                base = (i / 2) * 4 + (i % 2) * 2;
                write_cfg(IDX_W'(i), {ent[base + 1], ent[base]});
            end
        end
        write_cfg(IDX_W'(NUM_REGS + $urandom_range(0, 7)), {$urandom, $urandom});
        i_cfg_we <= 1'b0;
        matrix_settings++;
    endtask

    // Offer one request; record the owed result once it is taken
    task automatic send_point(input logic [31:0] x, y, z, input t_result want);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {z, y, x};
        do
            @(posedge i_clk);
        while (s_axis_tready !== 1'b1);
        projected_vertex_q.push_back(want);
        points_sent++;
        if (want.w_was_zero)
            flat_count++;
        gap = pick_gap(steady);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("[%0t] mismatch on %s: got %h, expected %h", $time, field, got, want);
    endtask

    // Back-pressure the result stream with the same gap profile as the sender
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end else begin
            m_axis_tready <= 1'b1;
            stall_left    <= pick_gap(steady);
        end
    end

    // Compare every accepted result against the oldest owed one
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (projected_vertex_q.size() == 0) begin
                report_mismatch("unrequested result", m_axis_tdata[31:0], '0);
            end else begin
                want = projected_vertex_q.pop_front();
                if (m_axis_tdata[31:0] !== want.out_x)
                    report_mismatch("out_x", m_axis_tdata[31:0], want.out_x);
                if (m_axis_tdata[63:32] !== want.out_y)
                    report_mismatch("out_y", m_axis_tdata[63:32], want.out_y);
                if (m_axis_tdata[95:64] !== want.out_z)
                    report_mismatch("out_z", m_axis_tdata[95:64], want.out_z);
                if (m_axis_tuser[0] !== want.w_was_zero)
                    report_mismatch("w_was_zero", 32'(m_axis_tuser[0]),
                                    32'(want.w_was_zero));
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        t_vertex_row row;
        t_mat_preset active;
        t_rand_kind  kind;
        logic [31:0] px, py, pz;
        int          phase_len;

        for (int i = 0; i < NUM_REGS; i++)
            matrix_q[i] = '0;

        // Reset matrix is all zero: w is zero, everything collapses to zero
        add_known(MAT_RESET, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1);
        add_known(MAT_RESET, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  32'h0, 32'h0, 32'h0, 1'b1);
        add_known(MAT_RESET, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h0, 32'h0, 32'h0, 1'b1);
        // Identity: the point passes straight through, divide by 1.0
        add_known(MAT_IDENTITY, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0);
        add_known(MAT_IDENTITY, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
                  32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000, 1'b0);
        add_known(MAT_IDENTITY, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000,
                  32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_0000, 1'b0);
        add_known(MAT_IDENTITY, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0000_0001,
                  32'h1234_5678, 32'h9ABC_DEF0, 32'h0000_0001, 1'b0);
        // Flat w column: translation shows through, floor shift and saturation
        add_known(MAT_FLAT, 32'h0, 32'h0, 32'h0,
                  32'h0001_8000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1'b1);
        add_row(MAT_FLAT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        add_row(MAT_FLAT, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        add_row(MAT_FLAT, 32'h0000_0001, 32'h0000_0001, 32'hFFFF_FFFF);
        // Projection with w = z: zero depth skips the divide
        add_known(MAT_PERSP, 32'h0003_0000, 32'hFFFE_8000, 32'h0,
                  32'h0003_0000, 32'hFFFE_8000, 32'h0, 1'b1);
        add_row(MAT_PERSP, 32'h0003_0000, 32'hFFFE_8000, 32'h0001_0000);
        add_row(MAT_PERSP, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFE_0000);
        add_row(MAT_PERSP, 32'h0064_0000, 32'h0001_0000, 32'h0000_0001);
        add_row(MAT_PERSP, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        // Every entry at the positive limit: origin gives sum / w = 1.0
        add_known(MAT_POS_MAX, 32'h0, 32'h0, 32'h0, Q_ONE, Q_ONE, Q_ONE, 1'b0);
        add_row(MAT_POS_MAX, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_row(MAT_POS_MAX, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
        // Every entry at the negative limit
        add_row(MAT_NEG_MAX, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_row(MAT_NEG_MAX, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_row(MAT_NEG_MAX, 32'h0000_0001, 32'h0000_0000, 32'hFFFF_FFFF);

        // Hold reset, then release it at an edge
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed table; reload the matrix whenever the preset changes
        active = MAT_RESET;
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.preset != active) begin
                program_matrix(build_preset(row.preset), 8'hFF);
                active = row.preset;
            end
            send_point(row.x, row.y, row.z,
                       row.has_golden ? row.golden : project_vertex(row.x, row.y, row.z));
        end

        // Random phases: new matrix each time, sometimes only part of it rewritten
        while (points_sent < POINT_TARGET) begin
            kind = t_rand_kind'($urandom_range(0, 3));
            steady <= ($urandom_range(0, 3) == 0);
            program_matrix(rand_matrix(kind),
                           ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'hFF);
            phase_len = $urandom_range(80, 200);
            repeat (phase_len) begin
                px = rand_coord();
                py = rand_coord();
                // Zero depth drives w to zero under the projection shape
                pz = ($urandom_range(0, 6) == 0) ? 32'h0 : rand_coord();
                send_point(px, py, pz, project_vertex(px, py, pz));
            end
        end

        // Drop the request, wait out all owed results, then watch for strays
        s_axis_tvalid <= 1'b0;
        while (projected_vertex_q.size() != 0)
            @(posedge i_clk);
        repeat (LAT + 8) @(posedge i_clk);
        if (projected_vertex_q.size() != 0)
            report_mismatch("results never delivered", projected_vertex_q.size(), 32'h0);

        $display("Sent %0d points through %0d matrix loads, including limit and identity cases",
                 points_sent, matrix_settings);
        $display("%0d points took the zero-w pass-through, %0d mismatches",
                 flat_count, mismatch_count);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/hvt_pkg.sv
rtl/hvt_mac_lane.sv
rtl/hvt_div_lane.sv
rtl/hvt_merge.sv
rtl/homogeneous_vertex_transform_unit.sv
rtl/hvt_checker.sv
sim/tb_homogeneous_vertex_transform_unit.sv
